>>> rtl/core/esrp_pkg.sv
// Shared types and constants for the ESC speed ramp pulse generator.
// No dependencies; imported by every module of the block.
package esrp_pkg;

    // Speed and pulse constants
    localparam int SPEED_W      = 8;
    localparam int MOTOR_W      = 4;
    localparam int PULSE_W      = 11;
    localparam int DUTY_W       = 16;
    localparam int MASK_W       = 16;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 8'sd100;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = -8'sd100;
    localparam logic signed [SPEED_W:0]   SPEED_STEP = 9'sd10;

    localparam logic signed [11:0] PULSE_CENTER = 12'sd1500;
    localparam logic [PULSE_W-1:0] PULSE_ARM    = 11'd1000;

    // duty = floor(p * 65535 / 20000)
    //      = floor(floor((p * 65535) / 32) / 625), the /625 done by reciprocal.
    localparam int DUTY_X_W    = PULSE_W + 16;          // p * 65535
    localparam int DUTY_Y_W    = DUTY_X_W - 5;          // after /32
    localparam int DUTY_K_W    = 23;
    localparam int DUTY_SHIFT  = 32;
    localparam int DUTY_PROD_W = DUTY_Y_W + DUTY_K_W;
    localparam logic [DUTY_K_W-1:0] DUTY_RECIP = 23'd6871948;  // ceil(2^32 / 625)

    // Command queue between front and back
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = 1;
    localparam int CMD_CNT_W = 2;

    // Stream payload widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic                       arm;      // reset motor to arming pulse
        logic [MOTOR_W-1:0]         motor;
        logic signed [SPEED_W-1:0]  target;   // already clamped
        logic                       ramp;     // step toward target by 10
    } cmd_t;

endpackage

>>> rtl/core/esc_speed_ramp_pulse_generator.sv
// The first result of a command passes through the command queue, the command registers,
// stage 1 and the output register. A command with n results (1..21) occupies the ramp
//   sequencer to load it and the stored speed, then one result per cycle unless stalled.
// The two-entry command queue lets new items be accepted while a ramp is running.
// Reset (rst_n low, asynchronous): queue and pipeline empty, all motor speeds zero,
//   inverted_mask zero.
module esc_speed_ramp_pulse_generator
    import esrp_pkg::*;
#(
    parameter int MOTOR_COUNT = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration: inverted_mask
    input  logic                  cfg_we,
    input  logic [MASK_W-1:0]     cfg_wdata,

    // command items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [3:0] motor_index, [11:4] target_speed,
                                                  // [12] soft_req, [15:13] zero
    input  logic [0:0]            s_axis_tuser,   // [0] action

    // pulse update items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [3:0] motor_out, [11:4] speed_out,
                                                  // [22:12] pulse_us, [38:23] duty, [39] zero
    output logic                  m_axis_tlast    // last
);

    // Per-motor direction bits; the user must write them only while the block is idle (not enforced).
    logic [MASK_W-1:0] inverted_mask_reg;

    logic                      push;
    cmd_t                      push_cmd;
    cmd_t                      head_cmd;
    logic                      fifo_full;
    logic                      fifo_empty;
    logic                      pop;
    logic [MOTOR_W-1:0]        out_motor;
    logic signed [SPEED_W-1:0] out_speed;
    logic [PULSE_W-1:0]        out_pulse;
    logic [DUTY_W-1:0]         out_duty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverted_mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            inverted_mask_reg <= cfg_wdata;
        end
    end

    // Front: motor range check and target clamp; out-of-range motors are
    // accepted and dropped without any result.
    esrp_front #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    esrp_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    // Back: with the ramp bit set, steps toward the target by 10 per result, then the target
    // itself with last set; otherwise the target alone; arming command gives a single 1000 us pulse.
    esrp_back #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .inverted_mask (inverted_mask_reg),
        .head_cmd      (head_cmd),
        .fifo_empty    (fifo_empty),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_motor     (out_motor),
        .out_speed     (out_speed),
        .out_pulse     (out_pulse),
        .out_duty      (out_duty),
        .out_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_duty, out_pulse, out_speed, out_motor};

endmodule

>>> rtl/core/esrp_front.sv
// Front end: takes input items, drops out-of-range motors, clamps targets.
// Depends on esrp_pkg; feeds esrp_cmd_fifo.
module esrp_front
    import esrp_pkg::*;
#(
    parameter int MOTOR_COUNT = 16
)
(
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  logic [0:0]            s_axis_tuser,
    input  logic                  fifo_full,
    output logic                  push,
    output cmd_t                  push_cmd
);

    logic [MOTOR_W-1:0]        motor;
    logic signed [SPEED_W-1:0] raw_target;
    logic                      motor_ok;

    assign motor      = s_axis_tdata[3:0];
    assign raw_target = s_axis_tdata[11:4];
    assign motor_ok   = ({28'd0, motor} < 32'(MOTOR_COUNT));

    assign s_axis_tready = !fifo_full;
    assign push          = s_axis_tvalid && s_axis_tready && motor_ok;

    always_comb
    begin
        push_cmd.arm   = s_axis_tuser[0];
        push_cmd.motor = motor;
        push_cmd.ramp  = s_axis_tdata[12];
        if (raw_target > SPEED_MAX)
        begin
            push_cmd.target = SPEED_MAX;
        end
        else if (raw_target < SPEED_MIN)
        begin
            push_cmd.target = SPEED_MIN;
        end
        else
        begin
            push_cmd.target = raw_target;
        end
    end

endmodule

>>> rtl/core/esrp_cmd_fifo.sv
// Short command queue decoupling the front end from the ramp sequencer.
// Depends on esrp_pkg (cmd_t, queue depth).
module esrp_cmd_fifo
    import esrp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic full,
    output logic empty
);

    cmd_t                 mem_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/esrp_back.sv
// Back end: ramp sequencer with the per-motor speed store, pulse and duty stages.
// Depends on esrp_pkg; pops commands from esrp_cmd_fifo.
module esrp_back
    import esrp_pkg::*;
#(
    parameter int MOTOR_COUNT = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [MASK_W-1:0]           inverted_mask,
    input  cmd_t                        head_cmd,
    input  logic                        fifo_empty,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [MOTOR_W-1:0]          out_motor,
    output logic signed [SPEED_W-1:0]   out_speed,
    output logic [PULSE_W-1:0]          out_pulse,
    output logic [DUTY_W-1:0]           out_duty,
    output logic                        out_last
);

    localparam int STORE_DEPTH = (MOTOR_COUNT < 16) ? MOTOR_COUNT : 16;
    localparam int SIDX_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    function automatic logic [PULSE_W-1:0] pulse_of(input logic signed [SPEED_W-1:0] s,
                                                    input logic inv);
        logic signed [11:0] two_s;
        logic signed [11:0] p;
        two_s = {{3{s[SPEED_W-1]}}, s, 1'b0};
        p     = inv ? (PULSE_CENTER - two_s) : (PULSE_CENTER + two_s);
        return p[PULSE_W-1:0];
    endfunction

    // speed store, cleared by reset
    logic signed [SPEED_W-1:0] store_reg [STORE_DEPTH];

    logic                      state_reg, state_next;
    logic                      arm_reg;
    logic                      soft_reg;
    logic                      up_reg;
    logic                      inv_reg;
    logic [MOTOR_W-1:0]        motor_reg;
    logic signed [SPEED_W-1:0] target_reg;
    logic signed [SPEED_W-1:0] cur_reg;

    // stage 1: speed and pulse
    logic                      s1_valid_reg, s1_valid_next;
    logic [MOTOR_W-1:0]        s1_motor_reg;
    logic signed [SPEED_W-1:0] s1_speed_reg;
    logic [PULSE_W-1:0]        s1_pulse_reg;
    logic                      s1_last_reg;

    // stage 2: output register with duty
    logic                      o_valid_reg, o_valid_next;
    logic [MOTOR_W-1:0]        o_motor_reg;
    logic signed [SPEED_W-1:0] o_speed_reg;
    logic [PULSE_W-1:0]        o_pulse_reg;
    logic [DUTY_W-1:0]         o_duty_reg;
    logic                      o_last_reg;

    logic                      o_free;
    logic                      s1_free;
    logic                      s1_move;
    logic                      emit;
    logic                      short;
    logic                      done;
    logic [SIDX_W-1:0]         head_idx;
    logic [SIDX_W-1:0]         cur_idx;
    logic signed [SPEED_W-1:0] head_old;
    logic signed [SPEED_W:0]   cur_sum;

    logic [DUTY_X_W-1:0]       duty_x;
    logic [DUTY_Y_W-1:0]       duty_y;
    logic [DUTY_PROD_W-1:0]    duty_prod;

    assign o_free  = !o_valid_reg || out_ready;
    assign s1_free = !s1_valid_reg || o_free;
    assign s1_move = s1_valid_reg && o_free;

    assign head_idx = head_cmd.motor[SIDX_W-1:0];
    assign cur_idx  = motor_reg[SIDX_W-1:0];
    assign head_old = store_reg[head_idx];

    assign pop   = (state_reg == ST_IDLE) && !fifo_empty;
    assign emit  = (state_reg == ST_RUN) && s1_free;
    assign short = !arm_reg && soft_reg && (up_reg ? (cur_reg < target_reg)
                                                    : (cur_reg > target_reg));
    assign done  = emit && !short;

    assign cur_sum = {cur_reg[SPEED_W-1], cur_reg} + (up_reg ? SPEED_STEP : -SPEED_STEP);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s1_valid_next = emit ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign o_valid_next  = s1_move ? 1'b1 : (out_ready ? 1'b0 : o_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
            if (done)
            begin
                store_reg[cur_idx] <= arm_reg ? '0 : target_reg;
            end
        end
    end

    // command registers and ramp position
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            arm_reg    <= head_cmd.arm;
            soft_reg   <= head_cmd.ramp;
            motor_reg  <= head_cmd.motor;
            target_reg <= head_cmd.target;
            cur_reg    <= head_old;
            up_reg     <= (head_cmd.target >= head_old);
            inv_reg    <= inverted_mask[head_cmd.motor];
        end
        else if (emit && short)
        begin
            cur_reg <= cur_sum[SPEED_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_motor_reg <= motor_reg;
            s1_last_reg  <= !short;
            if (arm_reg)
            begin
                s1_speed_reg <= '0;
                s1_pulse_reg <= PULSE_ARM;
            end
            else if (short)
            begin
                s1_speed_reg <= cur_reg;
                s1_pulse_reg <= pulse_of(cur_reg, inv_reg);
            end
            else
            begin
                s1_speed_reg <= target_reg;
                s1_pulse_reg <= pulse_of(target_reg, inv_reg);
            end
        end
    end

    // duty: p*65535 = p*65536 - p, drop 5 bits, then reciprocal of 625
    assign duty_x    = {s1_pulse_reg, 16'd0} - {16'd0, s1_pulse_reg};
    assign duty_y    = duty_x[DUTY_X_W-1:5];
    assign duty_prod = DUTY_PROD_W'(duty_y) * DUTY_PROD_W'(DUTY_RECIP);

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            o_motor_reg <= s1_motor_reg;
            o_speed_reg <= s1_speed_reg;
            o_pulse_reg <= s1_pulse_reg;
            o_last_reg  <= s1_last_reg;
            o_duty_reg  <= DUTY_W'(duty_prod[DUTY_PROD_W-1:DUTY_SHIFT]);
        end
    end

    assign out_valid = o_valid_reg;
    assign out_motor = o_motor_reg;
    assign out_speed = o_speed_reg;
    assign out_pulse = o_pulse_reg;
    assign out_duty  = o_duty_reg;
    assign out_last  = o_last_reg;

endmodule

>>> rtl/core/esrp_checker.sv
// Port-level checks for the ESC speed ramp pulse generator, bound to the top level.
// Depends on esrp_pkg for widths.
module esrp_checker
    import esrp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_we,
    input logic [MASK_W-1:0]     cfg_wdata,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [S_TDATA_W-1:0]  s_axis_tdata,
    input logic [0:0]            s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata,
    input logic                  m_axis_tlast
);

    logic signed [SPEED_W-1:0] speed;
    logic [PULSE_W-1:0]        pulse;

    assign speed = m_axis_tdata[11:4];
    assign pulse = m_axis_tdata[22:12];

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output item changed");

    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (pulse == 11'd1000) || (pulse >= 11'd1300 && pulse <= 11'd1700))
        else $error("pulse width out of range");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (speed >= SPEED_MIN) && (speed <= SPEED_MAX))
        else $error("speed out of range");

    a_arm_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && pulse == 11'd1000 |-> speed == '0 && m_axis_tlast)
        else $error("arming pulse with nonzero speed or not last");

endmodule

bind esc_speed_ramp_pulse_generator esrp_checker u_esrp_checker (.*);
